>>> hw/rtl/ipv4dq_pkg.sv
// ============================================================================
// ipv4dq_pkg
// Types and constants shared by the dotted-quad IPv4 address parser.
// ============================================================================
package ipv4dq_pkg;

   localparam int CharWidth    = 8;
   localparam int AccWidth     = 10;
   localparam int CountWidth   = 2;
   localparam int UpperWidth   = 24;
   localparam int AddressWidth = 32;

   localparam logic [CharWidth-1:0]  CHAR_END  = 8'h00;
   localparam logic [CharWidth-1:0]  CHAR_DOT  = 8'h2E;
   localparam logic [CharWidth-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CharWidth-1:0]  CHAR_NINE = 8'h39;

   localparam logic [AccWidth-1:0]   OCTET_MAX   = 10'd255;
   localparam logic [AccWidth-1:0]   ACC_LIMIT   = 10'd999;
   localparam logic [CountWidth-1:0] DIGIT_LIMIT = 2'd3;
   localparam logic [CountWidth-1:0] LAST_OCTET  = 2'd3;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
   } req_payload_type;

   typedef struct packed {
      logic                    valid_res;
      logic [AddressWidth-1:0] address;
   } rsp_payload_type;

   typedef struct packed {
      logic                 valid;
      logic [CharWidth-1:0] ch;
   } char_stage_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_stage_type;

endpackage

>>> hw/rtl/ipv4dq_stream_if.sv
// ============================================================================
// ipv4dq_stream_if
// Valid/ready stream channel; a transfer occurs when valid and ready are high.
// ============================================================================
interface ipv4dq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ipv4dq_input_stage.sv
// ============================================================================
// ipv4dq_input_stage
// Input register holding one character between the request channel and the
// parse logic.
// ============================================================================
module ipv4dq_input_stage (
   input  logic                      clock,
   input  logic                      reset,
   ipv4dq_stream_if.sink             req_if,
   input  logic                      advance,
   output ipv4dq_pkg::char_stage_type stage
);

   logic                             valid_ff;
   logic                             valid_in;
   logic [ipv4dq_pkg::CharWidth-1:0] ch_ff;
   logic                             take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign valid_in     = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         ch_ff <= req_if.payload.ch;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.ch    = ch_ff;

endmodule

>>> hw/rtl/ipv4dq_parse_core.sv
// ============================================================================
// ipv4dq_parse_core
// Per-character parse state and its combinational next-state update, and the formation
// of the result when the end byte arrives.
// ============================================================================
module ipv4dq_parse_core (
   input  logic                         clock,
   input  logic                         reset,
   input  ipv4dq_pkg::char_stage_type   stage,
   input  logic                         slot_free,
   output logic                         advance,
   output ipv4dq_pkg::result_stage_type result
);

   logic [ipv4dq_pkg::CountWidth-1:0] octet_index_ff, octet_index_in;
   logic [ipv4dq_pkg::CountWidth-1:0] digit_count_ff, digit_count_in;
   logic [ipv4dq_pkg::AccWidth-1:0]   accumulator_ff, accumulator_in;
   logic [ipv4dq_pkg::UpperWidth-1:0] upper_octets_ff, upper_octets_in;
   logic                              bad_ff, bad_in;

   logic                              is_end;
   logic                              is_digit;
   logic                              is_dot;
   logic [3:0]                        digit_offset;
   logic [ipv4dq_pkg::AccWidth-1:0]   acc_times_ten;
   logic                              ok;

   assign is_end   = (stage.ch == ipv4dq_pkg::CHAR_END);
   assign is_digit = (stage.ch >= ipv4dq_pkg::CHAR_ZERO) &&
                     (stage.ch <= ipv4dq_pkg::CHAR_NINE);
   assign is_dot   = (stage.ch == ipv4dq_pkg::CHAR_DOT);

   assign advance  = stage.valid && (!is_end || slot_free);

   assign digit_offset  = stage.ch[3:0] - ipv4dq_pkg::CHAR_ZERO[3:0];
   assign acc_times_ten = {accumulator_ff[ipv4dq_pkg::AccWidth-4:0], 3'b000} +
                          {accumulator_ff[ipv4dq_pkg::AccWidth-2:0], 1'b0};

   assign ok = !bad_ff && (octet_index_ff == ipv4dq_pkg::LAST_OCTET) &&
               (digit_count_ff != '0) && (accumulator_ff <= ipv4dq_pkg::OCTET_MAX);

   always_comb begin
      octet_index_in  = octet_index_ff;
      digit_count_in  = digit_count_ff;
      accumulator_in  = accumulator_ff;
      upper_octets_in = upper_octets_ff;
      bad_in          = bad_ff;
      if (is_end) begin
         octet_index_in  = '0;
         digit_count_in  = '0;
         accumulator_in  = '0;
         upper_octets_in = '0;
         bad_in          = 1'b0;
      end else if (!bad_ff) begin
         if (is_digit) begin
            if (digit_count_ff >= ipv4dq_pkg::DIGIT_LIMIT) begin
               bad_in = 1'b1;
            end else begin
               accumulator_in = acc_times_ten + {6'd0, digit_offset};
               digit_count_in = digit_count_ff + 2'd1;
            end
         end else if (is_dot) begin
            if ((digit_count_ff == '0) || (accumulator_ff > ipv4dq_pkg::OCTET_MAX) ||
                (octet_index_ff >= ipv4dq_pkg::LAST_OCTET)) begin
               bad_in = 1'b1;
            end else begin
               upper_octets_in = {upper_octets_ff[15:0], accumulator_ff[7:0]};
               octet_index_in  = octet_index_ff + 2'd1;
               digit_count_in  = '0;
               accumulator_in  = '0;
            end
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octet_index_ff  <= '0;
         digit_count_ff  <= '0;
         accumulator_ff  <= '0;
         upper_octets_ff <= '0;
         bad_ff          <= 1'b0;
      end else if (advance) begin
         octet_index_ff  <= octet_index_in;
         digit_count_ff  <= digit_count_in;
         accumulator_ff  <= accumulator_in;
         upper_octets_ff <= upper_octets_in;
         bad_ff          <= bad_in;
      end
   end

   assign result.valid             = advance && is_end;
   assign result.payload.valid_res = ok;
   assign result.payload.address   = ok ? {upper_octets_ff, accumulator_ff[7:0]} : '0;

   // An empty octet must never carry a value.
   a_empty_octet_zero: assert property (@(posedge clock) disable iff (reset)
      (digit_count_ff == '0) |-> (accumulator_ff == '0))
      else $error("accumulator non-zero with no digits");

   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      accumulator_ff <= ipv4dq_pkg::ACC_LIMIT)
      else $error("accumulator out of range");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (advance && is_end) |=> (octet_index_ff == '0 && digit_count_ff == '0 &&
                               upper_octets_ff == '0 && !bad_ff))
      else $error("state not cleared after end byte");

   a_result_needs_slot: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> slot_free)
      else $error("result produced without a free output slot");

   a_invalid_zero_address: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !result.payload.valid_res) |-> (result.payload.address == '0))
      else $error("invalid result carries a non-zero address");

endmodule

>>> hw/rtl/ipv4dq_output_stage.sv
// ============================================================================
// ipv4dq_output_stage
// Result register that holds one finished result until its transfer.
// ============================================================================
module ipv4dq_output_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  ipv4dq_pkg::result_stage_type result,
   output logic                         slot_free,
   ipv4dq_stream_if.source              rsp_if
);

   logic                        valid_ff;
   logic                        valid_in;
   ipv4dq_pkg::rsp_payload_type payload_ff;

   assign slot_free = !valid_ff || rsp_if.ready;
   assign valid_in  = result.valid ? 1'b1 : (rsp_if.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result.valid) begin
         payload_ff <= result.payload;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = payload_ff;

endmodule

>>> hw/rtl/ipv4_dotted_quad_parser.sv
// ============================================================================
// ipv4_dotted_quad_parser
// Streaming recogniser of strict dotted-quad IPv4 address text.
// Result path: input register, combinational parse update, result register.
// Throughput: one character per cycle, except that an end byte waits in the
// input register while the result register is full.
// Reset: synchronous; empties both registers and clears the parse state.
// ============================================================================
module ipv4_dotted_quad_parser (
   input  logic            clock,
   input  logic            reset,
   ipv4dq_stream_if.sink   req_if,
   ipv4dq_stream_if.source rsp_if
);

   ipv4dq_pkg::char_stage_type   stage;
   ipv4dq_pkg::result_stage_type result;
   logic                         advance;
   logic                         slot_free;

   ipv4dq_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   ipv4dq_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .slot_free (slot_free),
      .advance   (advance),
      .result    (result)
   );

   ipv4dq_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_if    (rsp_if)
   );

endmodule
